FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the span allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define FSBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define FSBA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/fsba_pkg.sv
// Types and constants of the free span block allocator.
`timescale 1ns / 1ps
package fsba_pkg;

  localparam int unsigned BLOCK_W     = 16;
  localparam int unsigned LEN_W       = BLOCK_W + 1;
  localparam int unsigned ADDR_EXT_W  = BLOCK_W + 2;
  localparam int unsigned ERASE_W     = 16;
  localparam logic [ERASE_W-1:0] ERASE_RESET = 16'd8;
  localparam logic [LEN_W-1:0]   SPACE_SIZE  = {1'b1, {BLOCK_W{1'b0}}};

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_PULL_ONE   = 2'd1,
    CMD_PULL_ERASE = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_RD, OP_RD1, OP_RDM1, OP_CAP, OP_CAPN, OP_NEXT,
    OP_ADD_END, OP_ADD_PRE, OP_WR, OP_WR_NEXT, OP_APPEND, OP_JOIN,
    OP_MOVE_DN, OP_MOVE_UP, OP_CNT_DEC, OP_PULL, OP_DIV_INIT, OP_DIV_STEP,
    OP_ALIGN, OP_ER_FRONT, OP_ER_BACK, OP_ER_DROP, OP_UP_SETUP,
    OP_WR_UPPER, OP_ER_LO, OP_SET_FULL, OP_SET_NONE, OP_CLEAR, OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_A_CHK, S_A_CAP, S_A_TEST, S_A_WR_J, S_A_CAPN,
    S_A_JTEST, S_A_JWR, S_WR_DONE, S_D_CHK, S_D_MOVE, S_P_CAP, S_P_ACT,
    S_P_TEST, S_E_CHK, S_E_CAP, S_E_DIV0, S_E_DIV, S_E_AL, S_E_TEST,
    S_U_CHK, S_U_MOVE, S_U_LO, S_DONE
  } ctrl_state_e;

  typedef struct packed {
    cmd_e cmd;
    logic sz_zero;
    logic e_zero;
    logic cnt_zero;
    logic cnt_full;
    logic idx_at_cnt;
    logic idx1_lt_cnt;
    logic idx_gt_pos1;
    logic end_eq_n;
    logic start_eq_nend;
    logic join_hit;
    logic len_zero;
    logic div_last;
    logic fits;
    logic al_at_start;
    logic len_eq_e;
    logic end_eq_ale;
  } dp_status_t;

endpackage

FILE: hdl/fsba_if.sv
// Handshake channel interfaces of the free span block allocator.
`timescale 1ns / 1ps
interface fsba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] first_block;
  logic [15:0] block_count;
  modport source (output valid, command, first_block, block_count, input ready);
  modport sink (input valid, command, first_block, block_count, output ready);
endinterface

interface fsba_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_number;
  logic [1:0]  status;
  modport source (output valid, block_number, status, input ready);
  modport sink (input valid, block_number, status, output ready);
endinterface

interface fsba_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hdl/fsba_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module fsba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/fsba_ctrl.sv
// Sequencing state machine of the free span block allocator.
`timescale 1ns / 1ps
module fsba_ctrl import fsba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t dp_i,
  output dp_op_e     op_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_o        = OP_NOP;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (dp_i.cmd)
          CMD_ADD: begin
            state_d = dp_i.sz_zero ? S_DONE : S_A_CHK;
          end
          CMD_PULL_ONE: begin
            if (dp_i.cnt_zero) begin
              op_o    = OP_SET_NONE;
              state_d = S_DONE;
            end else begin
              op_o    = OP_RD;
              state_d = S_P_CAP;
            end
          end
          CMD_PULL_ERASE: begin
            if (dp_i.e_zero) begin
              op_o    = OP_SET_NONE;
              state_d = S_DONE;
            end else begin
              state_d = S_E_CHK;
            end
          end
          CMD_CLEAR: begin
            op_o    = OP_CLEAR;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_A_CHK: begin
        if (dp_i.idx_at_cnt) begin
          op_o    = dp_i.cnt_full ? OP_SET_FULL : OP_APPEND;
          state_d = S_DONE;
        end else begin
          op_o    = OP_RD;
          state_d = S_A_CAP;
        end
      end
      S_A_CAP: begin
        op_o    = OP_CAP;
        state_d = S_A_TEST;
      end
      S_A_TEST: begin
        priority if (dp_i.end_eq_n) begin
          op_o    = OP_ADD_END;
          state_d = S_A_WR_J;
        end else if (dp_i.start_eq_nend) begin
          op_o    = OP_ADD_PRE;
          state_d = S_WR_DONE;
        end else begin
          op_o    = OP_NEXT;
          state_d = S_A_CHK;
        end
      end
      S_A_WR_J: begin
        if (dp_i.idx1_lt_cnt) begin
          op_o    = OP_RD1;
          state_d = S_A_CAPN;
        end else begin
          op_o    = OP_WR;
          state_d = S_DONE;
        end
      end
      S_A_CAPN: begin
        op_o    = OP_CAPN;
        state_d = S_A_JTEST;
      end
      S_A_JTEST: begin
        if (dp_i.join_hit) begin
          op_o    = OP_JOIN;
          state_d = S_A_JWR;
        end else begin
          op_o    = OP_WR;
          state_d = S_DONE;
        end
      end
      S_A_JWR: begin
        op_o    = OP_WR_NEXT;
        state_d = S_D_CHK;
      end
      S_WR_DONE: begin
        op_o    = OP_WR;
        state_d = S_DONE;
      end
      S_D_CHK: begin
        if (dp_i.idx1_lt_cnt) begin
          op_o    = OP_RD1;
          state_d = S_D_MOVE;
        end else begin
          op_o    = OP_CNT_DEC;
          state_d = S_DONE;
        end
      end
      S_D_MOVE: begin
        op_o    = OP_MOVE_DN;
        state_d = S_D_CHK;
      end
      S_P_CAP: begin
        op_o    = OP_CAP;
        state_d = S_P_ACT;
      end
      S_P_ACT: begin
        op_o    = OP_PULL;
        state_d = S_P_TEST;
      end
      S_P_TEST: begin
        if (dp_i.len_zero) begin
          state_d = S_D_CHK;
        end else begin
          op_o    = OP_WR;
          state_d = S_DONE;
        end
      end
      S_E_CHK: begin
        if (dp_i.idx_at_cnt) begin
          op_o    = OP_SET_NONE;
          state_d = S_DONE;
        end else begin
          op_o    = OP_RD;
          state_d = S_E_CAP;
        end
      end
      S_E_CAP: begin
        op_o    = OP_CAP;
        state_d = S_E_DIV0;
      end
      S_E_DIV0: begin
        op_o    = OP_DIV_INIT;
        state_d = S_E_DIV;
      end
      S_E_DIV: begin
        op_o = OP_DIV_STEP;
        if (dp_i.div_last) begin
          state_d = S_E_AL;
        end
      end
      S_E_AL: begin
        op_o    = OP_ALIGN;
        state_d = S_E_TEST;
      end
      S_E_TEST: begin
        priority if (!dp_i.fits) begin
          op_o    = OP_NEXT;
          state_d = S_E_CHK;
        end else if (dp_i.al_at_start && dp_i.len_eq_e) begin
          op_o    = OP_ER_DROP;
          state_d = S_D_CHK;
        end else if (dp_i.al_at_start) begin
          op_o    = OP_ER_FRONT;
          state_d = S_WR_DONE;
        end else if (dp_i.end_eq_ale) begin
          op_o    = OP_ER_BACK;
          state_d = S_WR_DONE;
        end else if (dp_i.cnt_full) begin
          op_o    = OP_SET_FULL;
          state_d = S_DONE;
        end else begin
          op_o    = OP_UP_SETUP;
          state_d = S_U_CHK;
        end
      end
      S_U_CHK: begin
        if (dp_i.idx_gt_pos1) begin
          op_o    = OP_RDM1;
          state_d = S_U_MOVE;
        end else begin
          op_o    = OP_WR_UPPER;
          state_d = S_U_LO;
        end
      end
      S_U_MOVE: begin
        op_o    = OP_MOVE_UP;
        state_d = S_U_CHK;
      end
      S_U_LO: begin
        op_o    = OP_ER_LO;
        state_d = S_WR_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          op_o        = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/fsba_datapath.sv
// Span table, working registers, remainder unit and result register.
`timescale 1ns / 1ps
module fsba_datapath import fsba_pkg::*; #(
  parameter int unsigned MAX_SPANS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_op_e              op_i,
  input  logic [1:0]          command_i,
  input  logic [BLOCK_W-1:0]  first_block_i,
  input  logic [BLOCK_W-1:0]  block_count_i,
  input  logic                cfg_we_i,
  input  logic [ERASE_W-1:0]  cfg_data_i,
  output dp_status_t          status_o,
  output logic [BLOCK_W-1:0]  block_number_o,
  output logic [1:0]          status_code_o
);

  localparam int unsigned IW  = $clog2(MAX_SPANS);
  localparam int unsigned CW  = $clog2(MAX_SPANS + 1);
  localparam int unsigned EW  = BLOCK_W + LEN_W;
  localparam int unsigned AW  = ADDR_EXT_W;
  localparam int unsigned BCW = $clog2(BLOCK_W);

  cmd_e               cmd_q;
  logic [BLOCK_W-1:0] n_q, s_q, ns_q, rem_q, dv_q, blk_q, out_blk_q;
  logic [LEN_W-1:0]   sz_q, l_q, nl_q;
  logic [ERASE_W-1:0] e_q;
  logic [CW-1:0]      cnt_q, idx_q, pos_q;
  logic [BCW-1:0]     bcnt_q;
  logic [AW-1:0]      al_q, end_q;
  status_e            st_q, out_st_q;

  logic               we;
  logic [IW-1:0]      raddr;
  logic [EW-1:0]      wdata, rdata;
  logic [CW-1:0]      idx_p1, idx_m1;
  logic [CW:0]        idx_p1_w, pos_p1_w;
  logic [LEN_W-1:0]   load_sum, load_sz, e_len;
  logic [AW-1:0]      s_ext, end_s, al_e, up_full, lo_full, al_d;
  logic [BLOCK_W:0]   div_t, div_e;
  logic [BLOCK_W-1:0] rem_d;

  fsba_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SPANS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(idx_q[IW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign idx_p1   = idx_q + 1'b1;
  assign idx_m1   = idx_q - 1'b1;
  assign idx_p1_w = {1'b0, idx_q} + 1'b1;
  assign pos_p1_w = {1'b0, pos_q} + 1'b1;
  assign e_len    = LEN_W'(e_q);
  assign s_ext    = AW'(s_q);
  assign end_s    = s_ext + AW'(l_q);
  assign al_e     = al_q + AW'(e_q);
  assign up_full  = end_q - al_e;
  assign lo_full  = al_q - s_ext;
  assign load_sum = LEN_W'(first_block_i) + LEN_W'(block_count_i);
  assign load_sz  = (load_sum > SPACE_SIZE) ? SPACE_SIZE - LEN_W'(first_block_i)
                                            : LEN_W'(block_count_i);
  assign div_t    = {rem_q, dv_q[BLOCK_W-1]};
  assign div_e    = (BLOCK_W+1)'(e_q);
  assign rem_d    = (div_t >= div_e) ? BLOCK_W'(div_t - div_e) : div_t[BLOCK_W-1:0];
  assign al_d     = (rem_q == '0) ? s_ext : s_ext + AW'(e_q) - AW'(rem_q);

  always_comb begin
    unique case (op_i)
      OP_RD1:  raddr = idx_p1[IW-1:0];
      OP_RDM1: raddr = idx_m1[IW-1:0];
      default: raddr = idx_q[IW-1:0];
    endcase
    we    = 1'b1;
    wdata = {s_q, l_q};
    unique case (op_i)
      OP_WR, OP_WR_NEXT:      wdata = {s_q, l_q};
      OP_APPEND:              wdata = {n_q, sz_q};
      OP_MOVE_DN, OP_MOVE_UP: wdata = rdata;
      OP_WR_UPPER:            wdata = {al_e[BLOCK_W-1:0], up_full[LEN_W-1:0]};
      default:                we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      e_q   <= ERASE_RESET;
    end else begin
      if (cfg_we_i) begin
        e_q <= cfg_data_i;
      end
      unique case (op_i)
        OP_APPEND, OP_WR_UPPER: cnt_q <= cnt_q + 1'b1;
        OP_CNT_DEC:             cnt_q <= cnt_q - 1'b1;
        OP_CLEAR:               cnt_q <= '0;
        default:                cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        cmd_q <= cmd_e'(command_i);
        n_q   <= first_block_i;
        sz_q  <= load_sz;
        idx_q <= '0;
        blk_q <= '0;
        st_q  <= ST_OK;
      end
      OP_CAP: begin
        s_q <= rdata[EW-1:LEN_W];
        l_q <= rdata[LEN_W-1:0];
      end
      OP_CAPN: begin
        ns_q <= rdata[EW-1:LEN_W];
        nl_q <= rdata[LEN_W-1:0];
      end
      OP_NEXT, OP_WR_NEXT, OP_MOVE_DN: idx_q <= idx_p1;
      OP_MOVE_UP: idx_q <= idx_m1;
      OP_ADD_END: l_q <= l_q + sz_q;
      OP_ADD_PRE: begin
        s_q <= n_q;
        l_q <= l_q + sz_q;
      end
      OP_JOIN: l_q <= l_q + nl_q;
      OP_PULL: begin
        blk_q <= s_q;
        s_q   <= s_q + 1'b1;
        l_q   <= l_q - 1'b1;
      end
      OP_DIV_INIT: begin
        rem_q  <= '0;
        dv_q   <= s_q;
        bcnt_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q  <= rem_d;
        dv_q   <= {dv_q[BLOCK_W-2:0], 1'b0};
        bcnt_q <= bcnt_q + 1'b1;
      end
      OP_ALIGN: begin
        al_q  <= al_d;
        end_q <= end_s;
      end
      OP_ER_FRONT: begin
        s_q   <= s_q + e_q;
        l_q   <= l_q - e_len;
        blk_q <= al_q[BLOCK_W-1:0];
      end
      OP_ER_BACK: begin
        l_q   <= l_q - e_len;
        blk_q <= al_q[BLOCK_W-1:0];
      end
      OP_ER_DROP: blk_q <= al_q[BLOCK_W-1:0];
      OP_UP_SETUP: begin
        pos_q <= idx_q;
        idx_q <= cnt_q;
      end
      OP_WR_UPPER: idx_q <= idx_m1;
      OP_ER_LO: begin
        l_q   <= lo_full[LEN_W-1:0];
        blk_q <= al_q[BLOCK_W-1:0];
      end
      OP_SET_FULL: st_q <= ST_FULL;
      OP_SET_NONE: st_q <= ST_NONE;
      OP_EMIT: begin
        out_blk_q <= blk_q;
        out_st_q  <= st_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.cmd           = cmd_q;
    status_o.sz_zero       = (sz_q == '0);
    status_o.e_zero        = (e_q == '0);
    status_o.cnt_zero      = (cnt_q == '0);
    status_o.cnt_full      = (cnt_q >= CW'(MAX_SPANS));
    status_o.idx_at_cnt    = (idx_q >= cnt_q);
    status_o.idx1_lt_cnt   = (idx_p1_w < {1'b0, cnt_q});
    status_o.idx_gt_pos1   = ({1'b0, idx_q} > pos_p1_w);
    status_o.end_eq_n      = (end_s == AW'(n_q));
    status_o.start_eq_nend = (s_ext == AW'(n_q) + AW'(sz_q));
    status_o.join_hit      = (AW'(ns_q) == end_s);
    status_o.len_zero      = (l_q == '0);
    status_o.div_last      = (bcnt_q == BCW'(BLOCK_W - 1));
    status_o.fits          = (end_q >= al_e);
    status_o.al_at_start   = (al_q == s_ext);
    status_o.len_eq_e      = (l_q == e_len);
    status_o.end_eq_ale    = (end_q == al_e);
  end

  assign block_number_o = out_blk_q;
  assign status_code_o  = out_st_q;

endmodule

FILE: hdl/free_span_block_allocator_core.sv
// Top level of the free span block allocator: controller, datapath and ports.
`timescale 1ns / 1ps
// Usage
// The block keeps an ordered table of free block spans and serves four
// commands on the req_i channel: add a range, pull one block, pull an
// aligned erase block and clear the table. Every accepted request word
// gives exactly one response word on rsp_o, carrying the pulled block
// number (zero when nothing was pulled) and a status.
// The erase block size is written through cfg_i, which is always ready;
// it should only be changed while no request is in flight.
// Requests are handled one at a time. An add scans the spans in order
// and moves spans when two spans merge. An erase pull scans the spans,
// aligning each span start with the one-bit-per-cycle remainder unit,
// and moves spans on a split. Every span entry lives in a table RAM
// with one read port, so spans are read and moved one at a time.
// A finished word waits in the output register; the next request is taken
// while it waits, and its result is held back until the receiver takes the
// earlier word. After reset the table is empty and the erase size is 8.
module free_span_block_allocator_core import fsba_pkg::*; #(
  parameter int unsigned MAX_SPANS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fsba_req_if.sink   req_i,
  fsba_rsp_if.source rsp_o,
  fsba_cfg_if.sink   cfg_i
);

  dp_status_t dp_status;
  dp_op_e     dp_op;

  // The configuration register is a plain write, so it never stalls.
  assign cfg_i.ready = 1'b1;

  fsba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .dp_i       (dp_status),
    .op_o       (dp_op)
  );

  fsba_datapath #(
    .MAX_SPANS(MAX_SPANS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (dp_op),
    .command_i     (req_i.command),
    .first_block_i (req_i.first_block),
    .block_count_i (req_i.block_count),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .status_o      (dp_status),
    .block_number_o(rsp_o.block_number),
    .status_code_o (rsp_o.status)
  );

endmodule

FILE: hdl/fsba_checker.sv
// Port-level checker of the free span block allocator and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fsba_checker import fsba_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] block_number_i,
  input logic [1:0]  status_i
);

  `FSBA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(block_number_i) && $stable(status_i), "stalled response word changed")
  `FSBA_ASSERT(a_status_code, out_valid_i |-> status_i == ST_OK || status_i == ST_NONE || status_i == ST_FULL, "unknown status code")
  `FSBA_ASSERT(a_fail_zero, out_valid_i && status_i != ST_OK |-> block_number_i == 16'd0, "failed pull returned a block")
  `FSBA_ASSERT(a_one_at_once, in_valid_i && in_ready_i |=> !in_ready_i, "request taken while one is in flight")
  `FSBA_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_i, "response word during reset")

endmodule

bind free_span_block_allocator_core fsba_checker u_fsba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .block_number_i(rsp_o.block_number),
  .status_i      (rsp_o.status)
);
